@@ rtl/core/fagr_pkg.sv @@
package fagr_pkg;

   localparam int Width = 32;

   typedef logic [Width-1:0] word_type;

   typedef enum logic [2:0] {
      ACT_LOAD = 3'd0,
      ACT_ADD  = 3'd1,
      ACT_SUB  = 3'd2,
      ACT_MUL  = 3'd3,
      ACT_DIV  = 3'd4
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_ADD,
      ST_GCD_START,
      ST_GCD_DIV,
      ST_GCD_STEP,
      ST_QN_START,
      ST_QN_DIV,
      ST_QD_START,
      ST_QD_DIV,
      ST_DONE
   } state_type;

   // Magnitude of a two's complement word.
   function automatic word_type mag(input word_type x);
      begin
         mag = x[Width-1] ? (~x + 1'b1) : x;
      end
   endfunction

endpackage

@@ rtl/core/fraction_accumulator_gcd_reduce.sv @@
// Fraction accumulator with gcd reduction.
// The req_ channel carries one item: an action code (load, add, subtract,
// multiply, divide) and a signed operand fraction. The rsp_ channel returns
// exactly one result per item: the new accumulator numerator and denominator,
// an overflow flag and a flag for an unreducible zero over zero.
// Items are handled one at a time. req_stall is high from the transfer of an
// item until its result has been taken. Cross products go through one shared
// 32 by 32 multiplier, one product a cycle (up to three). The Euclidean gcd and
// the two final quotients use one shared restoring divider that retires one
// quotient bit a cycle. The quotients are divided out only when the gcd is
// neither 0 nor 1; a load or an unused code goes straight to the result.
// The gcd takes up to about 46 remainder steps for 32-bit operands. After
// a result transfer the block returns to idle, where it takes the next item.
// While the result waits under rsp_stall the result registers hold and no
// new item is taken. Reset clears the accumulator to 0/1 and empties the block.
module fraction_accumulator_gcd_reduce
   import fagr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_action,
   input  logic signed [Width-1:0] req_operand_num,
   input  logic signed [Width-1:0] req_operand_den,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [Width-1:0] rsp_result_num,
   output logic signed [Width-1:0] rsp_result_den,
   output logic              rsp_overflow,
   output logic              rsp_zero_gcd
);

   localparam int CntW = $clog2(Width + 1);

   state_type state_ff, state_in;
   word_type acc_num_ff, acc_num_in, acc_den_ff, acc_den_in;
   logic [2:0] act_ff, act_in;
   word_type on_ff, on_in, od_ff, od_in;
   word_type p1_ff, p1_in, num_ff, num_in, den_ff, den_in;
   word_type ga_ff, ga_in, gb_ff, gb_in, gcd_ff, gcd_in;
   logic ov_ff, ov_in, zg_ff, zg_in;
   // Divider state.
   word_type dq_ff, dq_in, dr_ff, dr_in, dd_ff, dd_in;
   logic dneg_ff, dneg_in, dsa_ff, dsa_in;
   logic [CntW-1:0] dcnt_ff, dcnt_in;

   // Shared multiplier operands and result.
   word_type ma, mb, mprod;
   logic mov;
   logic [2*Width-1:0] mfull;
   logic mneg;
   word_type sum;
   logic [Width:0] rtrial;
   word_type rnext;
   word_type qmag;

   // Shared signed multiplier with wraparound and overflow detection.
   always_comb begin
      ma = '0;
      mb = '0;
      case (state_ff)
         ST_MUL1: begin
            if (act_ff == ACT_MUL) begin
               ma = acc_num_ff;
               mb = on_ff;
            end else if (act_ff == ACT_DIV) begin
               ma = acc_num_ff;
               mb = od_ff;
            end else begin
               ma = od_ff;
               mb = acc_num_ff;
            end
         end
         ST_MUL2: begin
            ma = acc_den_ff;
            mb = (act_ff == ACT_DIV) ? on_ff : od_ff;
         end
         ST_MUL3: begin
            ma = acc_den_ff;
            mb = on_ff;
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
      mfull = mag(ma) * mag(mb);
      mneg  = ma[Width-1] ^ mb[Width-1];
      // The signed product wraps to the low half, negated if the signs differ.
      mprod = mneg ? (~mfull[Width-1:0] + 1'b1) : mfull[Width-1:0];
      if (mneg) begin
         mov = (mfull > {{Width{1'b0}}, 1'b1, {(Width-1){1'b0}}});
      end else begin
         mov = (mfull > {{(Width+1){1'b0}}, {(Width-1){1'b1}}});
      end
   end

   assign sum = p1_ff + num_ff;

   // One restoring step of the shared divider on magnitudes.
   assign rtrial = {dr_ff, dq_ff[Width-1]} - {1'b0, dd_ff};
   assign rnext  = rtrial[Width] ? {dr_ff[Width-2:0], dq_ff[Width-1]} : rtrial[Width-1:0];
   assign qmag   = dq_ff;

   always_comb begin
      state_in   = state_ff;
      acc_num_in = acc_num_ff;
      acc_den_in = acc_den_ff;
      act_in     = act_ff;
      on_in      = on_ff;
      od_in      = od_ff;
      p1_in      = p1_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      ga_in      = ga_ff;
      gb_in      = gb_ff;
      gcd_in     = gcd_ff;
      ov_in      = ov_ff;
      zg_in      = zg_ff;
      dq_in      = dq_ff;
      dr_in      = dr_ff;
      dd_in      = dd_ff;
      dneg_in    = dneg_ff;
      dsa_in     = dsa_ff;
      dcnt_in    = dcnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               act_in = req_action;
               on_in  = req_operand_num;
               od_in  = req_operand_den;
               ov_in  = 1'b0;
               zg_in  = 1'b0;
               num_in = acc_num_ff;
               den_in = acc_den_ff;
               case (req_action)
                  ACT_LOAD: begin
                     num_in   = req_operand_num;
                     den_in   = req_operand_den;
                     state_in = ST_DONE;
                  end
                  ACT_SUB: begin
                     // Negation of the most negative value wraps to itself.
                     on_in    = ~req_operand_num + 1'b1;
                     ov_in    = (req_operand_num == {1'b1, {(Width-1){1'b0}}});
                     state_in = ST_MUL1;
                  end
                  ACT_ADD, ACT_MUL, ACT_DIV: state_in = ST_MUL1;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_MUL1: begin
            ov_in = ov_ff | mov;
            if (act_ff == ACT_ADD || act_ff == ACT_SUB) begin
               p1_in = mprod;
            end else begin
               num_in = mprod;
            end
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            ov_in  = ov_ff | mov;
            den_in = mprod;
            state_in = (act_ff == ACT_ADD || act_ff == ACT_SUB) ? ST_MUL3 : ST_GCD_START;
         end
         ST_MUL3: begin
            ov_in    = ov_ff | mov;
            num_in   = mprod;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            // Sum of the two cross products with signed overflow check.
            num_in = sum;
            if (p1_ff[Width-1] == num_ff[Width-1] && sum[Width-1] != p1_ff[Width-1]) begin
               ov_in = 1'b1;
            end
            state_in = ST_GCD_START;
         end
         ST_GCD_START: begin
            ga_in    = num_ff;
            gb_in    = den_ff;
            state_in = ST_GCD_STEP;
         end
         ST_GCD_STEP: begin
            // Euclid loop: stop when the second operand is zero.
            if (gb_ff == '0) begin
               gcd_in = ga_ff;
               if (ga_ff == '0) begin
                  zg_in    = 1'b1;
                  state_in = ST_DONE;
               end else if (ga_ff == {{(Width-1){1'b0}}, 1'b1}) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_QN_START;
               end
            end else begin
               dq_in    = mag(ga_ff);
               dr_in    = '0;
               dd_in    = mag(gb_ff);
               dsa_in   = ga_ff[Width-1];
               dcnt_in  = CntW'(Width);
               state_in = ST_GCD_DIV;
            end
         end
         ST_GCD_DIV: begin
            if (dcnt_ff == '0) begin
               // Remainder takes the sign of the dividend.
               ga_in    = gb_ff;
               gb_in    = dsa_ff ? (~dr_ff + 1'b1) : dr_ff;
               state_in = ST_GCD_STEP;
            end else begin
               dr_in   = rnext;
               dq_in   = {dq_ff[Width-2:0], ~rtrial[Width]};
               dcnt_in = dcnt_ff - 1'b1;
            end
         end
         ST_QN_START, ST_QD_START: begin
            dq_in    = mag((state_ff == ST_QN_START) ? num_ff : den_ff);
            dr_in    = '0;
            dd_in    = mag(gcd_ff);
            dneg_in  = ((state_ff == ST_QN_START) ? num_ff[Width-1] : den_ff[Width-1])
                       ^ gcd_ff[Width-1];
            dcnt_in  = CntW'(Width);
            state_in = (state_ff == ST_QN_START) ? ST_QN_DIV : ST_QD_DIV;
         end
         ST_QN_DIV, ST_QD_DIV: begin
            if (dcnt_ff == '0) begin
               // Quotient sign and overflow of a positive result past the range.
               if (!dneg_ff && qmag[Width-1]) begin
                  ov_in = 1'b1;
               end
               if (state_ff == ST_QN_DIV) begin
                  num_in   = dneg_ff ? (~qmag + 1'b1) : qmag;
                  state_in = ST_QD_START;
               end else begin
                  den_in   = dneg_ff ? (~qmag + 1'b1) : qmag;
                  state_in = ST_DONE;
               end
            end else begin
               dr_in   = rnext;
               dq_in   = {dq_ff[Width-2:0], ~rtrial[Width]};
               dcnt_in = dcnt_ff - 1'b1;
            end
         end
         ST_DONE: begin
            acc_num_in = num_ff;
            acc_den_in = den_ff;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control and accumulator registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         acc_num_ff <= '0;
         acc_den_ff <= {{(Width-1){1'b0}}, 1'b1};
      end else begin
         state_ff   <= state_in;
         acc_num_ff <= acc_num_in;
         acc_den_ff <= acc_den_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      act_ff  <= act_in;
      on_ff   <= on_in;
      od_ff   <= od_in;
      p1_ff   <= p1_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      ga_ff   <= ga_in;
      gb_ff   <= gb_in;
      gcd_ff  <= gcd_in;
      ov_ff   <= ov_in;
      zg_ff   <= zg_in;
      dq_ff   <= dq_in;
      dr_ff   <= dr_in;
      dd_ff   <= dd_in;
      dneg_ff <= dneg_in;
      dsa_ff  <= dsa_in;
      dcnt_ff <= dcnt_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_DONE);
   assign rsp_result_num = num_ff;
   assign rsp_result_den = den_ff;
   assign rsp_overflow   = ov_ff;
   assign rsp_zero_gcd   = zg_ff;

   // A result is only offered while no new item can be taken.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> req_stall)
      else $error("result offered while input open");

   // The zero gcd flag implies an all-zero fraction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_gcd |-> (num_ff == '0 && den_ff == '0))
      else $error("zero gcd flag on nonzero fraction");

   // A transfer of an item always starts work on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != ST_IDLE)
      else $error("accepted item dropped");

   // A stalled result stays on the channel.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_num))
      else $error("stalled result changed");

endmodule

@@ tb/sv/fraction_accumulator_gcd_reduce_tb.sv @@
module fraction_accumulator_gcd_reduce_tb
   import fagr_pkg::*;
();

   localparam logic [2:0] ActSpare5 = 3'd5;
   localparam logic [2:0] ActSpare6 = 3'd6;
   localparam logic [2:0] ActSpare7 = 3'd7;
   localparam logic [31:0] MostNeg = 32'h8000_0000;
   localparam logic [31:0] MostPos = 32'h7fff_ffff;
   localparam int RandomItems = 2000;
   localparam int SettleCycles = 2000;

   typedef struct {
      logic [2:0]  action;
      logic [31:0] num;
      logic [31:0] den;
      bit          drain;
   } frac_item_type;

   typedef struct {
      logic [31:0] num;
      logic [31:0] den;
      logic        overflow;
      logic        zero_gcd;
   } frac_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_action = '0;
   logic signed [31:0] req_operand_num = '0;
   logic signed [31:0] req_operand_den = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_result_num;
   logic signed [31:0] rsp_result_den;
   logic rsp_overflow;
   logic rsp_zero_gcd;

   frac_item_type pending_items[$];
   frac_result_type expected_fracs[$];
   logic [31:0] acc_num_model;
   logic [31:0] acc_den_model;
   bit taken = 1'b0;
   bit drain_wait = 1'b0;
   bit quiet_phase = 1'b0;
   int send_gap = 0;
   int recv_gap = 0;
   int errors = 0;

   fraction_accumulator_gcd_reduce i_dut (.*);

   always #10 clock = ~clock;

   // Signed helpers at the block's word width.
   function automatic logic [31:0] magnitude(input logic [31:0] x);
      return x[31] ? -x : x;
   endfunction

   function automatic logic [31:0] wrap_mul(input logic [31:0] a, input logic [31:0] b,
                                            inout logic ov);
      longint p;
      p = longint'($signed(a)) * longint'($signed(b));
      if (p > 64'sd2147483647 || p < -64'sd2147483648) ov = 1'b1;
      return a * b;
   endfunction

   function automatic logic [31:0] wrap_add(input logic [31:0] a, input logic [31:0] b,
                                            inout logic ov);
      logic [31:0] s;
      s = a + b;
      if (a[31] == b[31] && s[31] != a[31]) ov = 1'b1;
      return s;
   endfunction

   function automatic logic [31:0] trunc_rem(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] r;
      r = magnitude(a) % magnitude(b);
      return a[31] ? -r : r;
   endfunction

   function automatic logic [31:0] trunc_quot(input logic [31:0] a, input logic [31:0] b,
                                              inout logic ov);
      logic [31:0] q;
      q = magnitude(a) / magnitude(b);
      if (a[31] != b[31]) return -q;
      if (q > MostPos) ov = 1'b1;
      return q;
   endfunction

   // Works out the new accumulator for one item and records it as expected.
   function automatic void predict_fraction(input frac_item_type it);
      frac_result_type r;
      logic [31:0] on, p1, p2, a, b, t;
      bit reduce;
      on = it.num;
      r.num = acc_num_model;
      r.den = acc_den_model;
      r.overflow = 1'b0;
      r.zero_gcd = 1'b0;
      reduce = 1'b1;
      case (it.action)
         ACT_LOAD: begin
            r.num = it.num;
            r.den = it.den;
            reduce = 1'b0;
         end
         ACT_ADD, ACT_SUB: begin
            if (it.action == ACT_SUB) begin
               if (on == MostNeg) r.overflow = 1'b1;
               on = -on;
            end
            p1 = wrap_mul(it.den, acc_num_model, r.overflow);
            p2 = wrap_mul(acc_den_model, on, r.overflow);
            r.num = wrap_add(p1, p2, r.overflow);
            r.den = wrap_mul(acc_den_model, it.den, r.overflow);
         end
         ACT_MUL: begin
            r.num = wrap_mul(acc_num_model, it.num, r.overflow);
            r.den = wrap_mul(acc_den_model, it.den, r.overflow);
         end
         ACT_DIV: begin
            r.num = wrap_mul(acc_num_model, it.den, r.overflow);
            r.den = wrap_mul(acc_den_model, it.num, r.overflow);
         end
         default: reduce = 1'b0;
      endcase
      if (reduce) begin
         a = r.num;
         b = r.den;
         while (b != 0) begin
            t = trunc_rem(a, b);
            a = b;
            b = t;
         end
         if (a == 0) begin
            r.zero_gcd = 1'b1;
         end else if (a != 32'd1) begin
            r.num = trunc_quot(r.num, a, r.overflow);
            r.den = trunc_quot(r.den, a, r.overflow);
         end
      end
      acc_num_model = r.num;
      acc_den_model = r.den;
      expected_fracs.push_back(r);
   endfunction

   // Operand values: mostly small so that reductions are common, some full range.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 32'($signed($urandom_range(0, 40)) - 20);
         4, 5: return 32'($signed($urandom_range(0, 4000)) - 2000);
         6: return $urandom_range(0, 1) ? MostNeg : MostPos;
         7: return 32'($signed($urandom_range(0, 6)) - 3);
         default: return $urandom;
      endcase
   endfunction

   function automatic void add_item(input logic [2:0] act, input logic [31:0] n,
                                    input logic [31:0] d, input bit drain = 1'b0);
      frac_item_type it;
      it.action = act;
      it.num = n;
      it.den = d;
      it.drain = drain;
      pending_items.push_back(it);
   endfunction

   // Record every request transfer and check every result transfer.
   always @(posedge clock) begin
      frac_result_type e;
      if (!reset && req_valid && !req_stall) begin
         predict_fraction('{req_action, req_operand_num, req_operand_den, 1'b0});
         taken = 1'b1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_fracs.size() == 0) begin
            $error("result transfer with no result expected");
            errors++;
         end else begin
            e = expected_fracs.pop_front();
            if (rsp_result_num !== e.num) begin
               $error("result_num expected %0d actual %0d", $signed(e.num), rsp_result_num);
               errors++;
            end
            if (rsp_result_den !== e.den) begin
               $error("result_den expected %0d actual %0d", $signed(e.den), rsp_result_den);
               errors++;
            end
            if (rsp_overflow !== e.overflow) begin
               $error("overflow expected %0b actual %0b", e.overflow, rsp_overflow);
               errors++;
            end
            if (rsp_zero_gcd !== e.zero_gcd) begin
               $error("zero_gcd expected %0b actual %0b", e.zero_gcd, rsp_zero_gcd);
               errors++;
            end
         end
      end
   end

   // Request driver: presents queued items with random idle bursts.
   always @(negedge clock) begin
      frac_item_type it;
      if (!reset && (!req_valid || taken)) begin
         taken = 1'b0;
         if (drain_wait && expected_fracs.size() != 0) begin
            req_valid <= 1'b0;
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (!quiet_phase && pending_items.size() > 0 && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 3);
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            it = pending_items[0];
            if (it.drain && !drain_wait && expected_fracs.size() != 0) begin
               drain_wait = 1'b1;
               req_valid <= 1'b0;
            end else begin
               void'(pending_items.pop_front());
               drain_wait = 1'b0;
               req_valid <= 1'b1;
               req_action <= it.action;
               req_operand_num <= it.num;
               req_operand_den <= it.den;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side: random stall bursts.
   always @(negedge clock) begin
      if (quiet_phase) begin
         rsp_stall <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
         recv_gap = $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      int n;
      acc_num_model = 32'd0;
      acc_den_model = 32'd1;
      // Directed part: extremes, each action, zero over zero, wraps, unused codes.
      add_item(ACT_ADD, 32'd1, 32'd2);
      add_item(ACT_LOAD, MostNeg, MostPos);
      add_item(ACT_LOAD, 32'd6, 32'd4);
      add_item(ACT_ADD, 32'd1, 32'd3);
      add_item(ACT_SUB, 32'd5, 32'd6);
      add_item(ACT_MUL, 32'd9, -32'd4);
      add_item(ACT_DIV, 32'd3, 32'd7);
      add_item(ACT_SUB, MostNeg, 32'd1);
      add_item(ACT_LOAD, MostNeg, -32'd1);
      add_item(ACT_MUL, 32'd1, 32'd1);
      add_item(ACT_LOAD, 32'd0, 32'd1);
      add_item(ACT_MUL, 32'd5, 32'd0);
      add_item(ACT_ADD, 32'd0, 32'd0);
      add_item(ACT_LOAD, 32'd5, 32'd0);
      add_item(ACT_DIV, 32'd1, 32'd1);
      add_item(ACT_LOAD, MostPos, MostPos);
      add_item(ACT_MUL, MostPos, MostNeg);
      add_item(ACT_LOAD, -32'd1, 32'hffff_ffff);
      add_item(ActSpare5, MostNeg, MostPos);
      add_item(ActSpare6, 32'hffff_ffff, 32'd0);
      add_item(ActSpare7, 32'd0, 32'hffff_ffff, 1'b1);
      add_item(ACT_DIV, 32'd0, 32'd3);
      // Random part: loads with short arithmetic runs, and some fully random items.
      n = 0;
      while (n < RandomItems) begin
         if ($urandom_range(0, 5) == 0) begin
            add_item(3'($urandom_range(0, 7)), $urandom, $urandom);
         end else begin
            add_item(ACT_LOAD, pick_value(), pick_value());
            repeat ($urandom_range(1, 6)) begin
               add_item(3'($urandom_range(1, 4)), pick_value(), pick_value(),
                        $urandom_range(0, 150) == 0);
               n++;
            end
         end
         n++;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (pending_items.size() < 200);
      quiet_phase = 1'b1;
      wait (pending_items.size() == 0 && expected_fracs.size() == 0 && !req_valid);
      repeat (SettleCycles) @(posedge clock);
      if (errors == 0 && expected_fracs.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog for a hung block.
   initial begin
      #400_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/fagr_pkg.sv
rtl/core/fraction_accumulator_gcd_reduce.sv
tb/sv/fraction_accumulator_gcd_reduce_tb.sv
